// File: sv/icmppt_pkg.sv
// Shared types and constants for the incremental conductance MPPT unit.
// Used by the controller, the datapath, the divider and the top level.
package icmppt_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SAMPLE_X_W = SAMPLE_W + 1;
    localparam int DIV_W      = SAMPLE_W + 16;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int G_W        = DIV_W + 2;

    localparam int DUTY_W     = 16;
    localparam int DUTY_X_W   = DUTY_W + 2;
    localparam int STEP_W     = 12;
    localparam int BAND_W     = 8;
    localparam int GBAND_W    = 16;
    localparam int PWM_W      = 12;
    localparam int ACT_W      = 2;

    localparam int S_TDATA_W  = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = DUTY_W + 2 * PWM_W + ACT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [DUTY_W-1:0]  DUTY_MIN_RST   = 16'd32768;
    localparam logic [DUTY_W-1:0]  DUTY_MAX_RST   = 16'd58982;
    localparam logic [STEP_W-1:0]  DUTY_STEP_RST  = 12'd131;
    localparam logic [BAND_W-1:0]  VBAND_RST      = 8'd3;
    localparam logic [BAND_W-1:0]  IBAND_RST      = 8'd3;
    localparam logic [GBAND_W-1:0] GBAND_RST      = 16'd655;
    localparam logic [PWM_W-1:0]   PWM_FS_RST     = 12'd603;
    localparam logic [DUTY_W:0]    DUTY_ONE       = 17'h10000;

    typedef enum logic [ACT_W-1:0] {
        ACT_HOLD = 2'd0,
        ACT_DEC  = 2'd1,
        ACT_INC  = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DUTY_MIN  = 3'd0,
        CFG_DUTY_MAX  = 3'd1,
        CFG_DUTY_STEP = 3'd2,
        CFG_VBAND     = 3'd3,
        CFG_IBAND     = 3'd4,
        CFG_GBAND     = 3'd5,
        CFG_PWM_FS    = 3'd6
    } cfg_idx_t;

    typedef enum logic {
        DIV_IV   = 1'b0,
        DIV_DIDV = 1'b1
    } div_src_t;

    typedef enum logic [1:0] {
        SRC_DI  = 2'd0,
        SRC_DEC = 2'd1,
        SRC_G   = 2'd2
    } act_src_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_DIV1,
        ST_DIV2,
        ST_DECIDE,
        ST_STEP,
        ST_PWM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic     capture;
        logic     div_start;
        div_src_t div_src;
        logic     save_q1;
        logic     clear_q1;
        logic     save_g;
        logic     act_load;
        act_src_t act_src;
        logic     step;
        logic     pwm;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic dv_small;
        logic v_zero;
        logic i_zero;
        logic div_done;
    } dp_sts_t;

endpackage

// File: sv/icmppt_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on icmppt_pkg for the dividend and divisor widths.
module icmppt_div import icmppt_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [DIV_W-1:0]    dividend,
    input  logic [SAMPLE_W-1:0] divisor,
    output logic [DIV_W-1:0]    quotient,
    output logic                done
);

    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [SAMPLE_W-1:0]  rem_reg, rem_next;
    logic [SAMPLE_W-1:0]  dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [SAMPLE_X_W-1:0] trial;
    logic [SAMPLE_X_W-1:0] diff;
    logic                  fits;

    // The dividend shifts out of the top of quo_reg while quotient bits enter at the bottom.
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = DIV_CNT_W'(DIV_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while a division is running");

    a_done_on_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && cnt_reg == DIV_CNT_W'(1) && !start) |=> done_reg)
        else $error("divider did not finish after its last bit");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (!busy_reg && $past(busy_reg)))
        else $error("divider done without a preceding division");

endmodule

// File: sv/icmppt_dp.sv
// Datapath: configuration registers, sample history, conductance sum, duty step and PWM counts.
// Depends on icmppt_pkg and instantiates icmppt_div.
module icmppt_dp import icmppt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  dp_cmd_t               cmd,
    output dp_sts_t               sts,
    output logic [M_TDATA_W-1:0]  m_tdata
);

    logic [DUTY_W-1:0]  duty_min_reg;
    logic [DUTY_W-1:0]  duty_max_reg;
    logic [STEP_W-1:0]  duty_step_reg;
    logic [BAND_W-1:0]  vband_reg;
    logic [BAND_W-1:0]  iband_reg;
    logic [GBAND_W-1:0] gband_reg;
    logic [PWM_W-1:0]   pwm_fs_reg;

    logic [SAMPLE_W-1:0]   prev_v_reg;
    logic [SAMPLE_W-1:0]   prev_i_reg;
    logic [DUTY_W-1:0]     duty_state_reg;

    logic [SAMPLE_W-1:0]   v_reg;
    logic [SAMPLE_W-1:0]   i_reg;
    logic [SAMPLE_X_W-1:0] dv_reg;
    logic [SAMPLE_X_W-1:0] di_reg;
    logic [DIV_W-1:0]      q1_reg;
    logic signed [G_W-1:0] g_reg;
    action_t               act_reg;
    logic [DUTY_W-1:0]     duty_reg;
    logic [PWM_W-1:0]      hi_reg;
    logic [PWM_W-1:0]      lo_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;

    logic [SAMPLE_W-1:0]   s_v;
    logic [SAMPLE_W-1:0]   s_i;
    logic [SAMPLE_X_W-1:0] abs_dv;
    logic [SAMPLE_X_W-1:0] abs_di;
    logic [DIV_W-1:0]      div_dividend;
    logic [SAMPLE_W-1:0]   div_divisor;
    logic [DIV_W-1:0]      div_quotient;
    logic                  div_done;
    logic [G_W-1:0]        q2_ext;
    logic signed [G_W-1:0] g_sum;
    logic signed [SAMPLE_X_W-1:0] iband_s;
    logic signed [G_W-1:0]        gband_s;
    action_t               act_di;
    action_t               act_g;
    action_t               act_next;
    logic signed [DUTY_X_W-1:0] d_step;
    logic signed [DUTY_X_W-1:0] d_hi_clamp;
    logic signed [DUTY_X_W-1:0] d_clamp;
    logic [DUTY_W+PWM_W-1:0]    hi_prod;
    logic [DUTY_W+PWM_W-1:0]    lo_prod;

    assign s_v = s_tdata[SAMPLE_W-1:0];
    assign s_i = s_tdata[2*SAMPLE_W-1:SAMPLE_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_min_reg  <= DUTY_MIN_RST;
            duty_max_reg  <= DUTY_MAX_RST;
            duty_step_reg <= DUTY_STEP_RST;
            vband_reg     <= VBAND_RST;
            iband_reg     <= IBAND_RST;
            gband_reg     <= GBAND_RST;
            pwm_fs_reg    <= PWM_FS_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_DUTY_MIN:  duty_min_reg  <= cfg_data[DUTY_W-1:0];
                CFG_DUTY_MAX:  duty_max_reg  <= cfg_data[DUTY_W-1:0];
                CFG_DUTY_STEP: duty_step_reg <= cfg_data[STEP_W-1:0];
                CFG_VBAND:     vband_reg     <= cfg_data[BAND_W-1:0];
                CFG_IBAND:     iband_reg     <= cfg_data[BAND_W-1:0];
                CFG_GBAND:     gband_reg     <= cfg_data[GBAND_W-1:0];
                CFG_PWM_FS:    pwm_fs_reg    <= cfg_data[PWM_W-1:0];
                default: ;
            endcase
        end
    end

    assign abs_dv = dv_reg[SAMPLE_W] ? (~dv_reg + 1'b1) : dv_reg;
    assign abs_di = di_reg[SAMPLE_W] ? (~di_reg + 1'b1) : di_reg;

    assign sts.dv_small = abs_dv <= SAMPLE_X_W'(vband_reg);
    assign sts.v_zero   = v_reg == '0;
    assign sts.i_zero   = i_reg == '0;
    assign sts.div_done = div_done;

    // The first pass divides I by V, the second |dI| by |dV|; both dividends carry 16 fraction bits.
    assign div_dividend = (cmd.div_src == DIV_IV) ? {i_reg, 16'b0}
                                                  : {abs_di[SAMPLE_W-1:0], 16'b0};
    assign div_divisor  = (cmd.div_src == DIV_IV) ? v_reg : abs_dv[SAMPLE_W-1:0];

    icmppt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // The dI/dV quotient takes the sign of dI xor dV, which truncates toward zero.
    assign q2_ext = {2'b00, div_quotient};
    assign g_sum  = $signed({2'b00, q1_reg})
                  + ((dv_reg[SAMPLE_W] ^ di_reg[SAMPLE_W]) ? $signed(~q2_ext + 1'b1)
                                                           : $signed(q2_ext));

    assign iband_s = $signed(SAMPLE_X_W'(iband_reg));
    assign gband_s = $signed(G_W'(gband_reg));

    always_comb begin
        if ($signed(di_reg) > iband_s) begin
            act_di = ACT_DEC;
        end else if ($signed(di_reg) < -iband_s) begin
            act_di = ACT_INC;
        end else begin
            act_di = ACT_HOLD;
        end
        if (g_reg > gband_s) begin
            act_g = ACT_DEC;
        end else if (g_reg < -gband_s) begin
            act_g = ACT_INC;
        end else begin
            act_g = ACT_HOLD;
        end
        case (cmd.act_src)
            SRC_DI:  act_next = act_di;
            SRC_DEC: act_next = ACT_DEC;
            SRC_G:   act_next = act_g;
            default: act_next = ACT_HOLD;
        endcase
    end

    always_comb begin
        case (act_reg)
            ACT_DEC: d_step = $signed({2'b00, duty_state_reg})
                            - $signed(DUTY_X_W'(duty_step_reg));
            ACT_INC: d_step = $signed({2'b00, duty_state_reg})
                            + $signed(DUTY_X_W'(duty_step_reg));
            default: d_step = $signed({2'b00, duty_state_reg});
        endcase
        // Upper clamp first, then lower, so crossed limits settle on duty_min.
        d_hi_clamp = (d_step >= $signed({2'b00, duty_max_reg})) ? $signed({2'b00, duty_max_reg})
                                                               : d_step;
        d_clamp    = (d_hi_clamp <= $signed({2'b00, duty_min_reg}))
                   ? $signed({2'b00, duty_min_reg}) : d_hi_clamp;
    end

    assign hi_prod = duty_reg * pwm_fs_reg;
    assign lo_prod = (DUTY_ONE - {1'b0, duty_reg}) * pwm_fs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_v_reg     <= '0;
            prev_i_reg     <= '0;
            duty_state_reg <= '0;
        end else if (cmd.load_out) begin
            prev_v_reg     <= v_reg;
            prev_i_reg     <= i_reg;
            duty_state_reg <= duty_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            v_reg  <= s_v;
            i_reg  <= s_i;
            dv_reg <= {1'b0, s_v} - {1'b0, prev_v_reg};
            di_reg <= {1'b0, s_i} - {1'b0, prev_i_reg};
        end
        if (cmd.clear_q1) begin
            q1_reg <= '0;
        end else if (cmd.save_q1) begin
            q1_reg <= div_quotient;
        end
        if (cmd.save_g) begin
            g_reg <= g_sum;
        end
        if (cmd.act_load) begin
            act_reg <= act_next;
        end
        if (cmd.step) begin
            duty_reg <= d_clamp[DUTY_W-1:0];
        end
        if (cmd.pwm) begin
            hi_reg <= hi_prod[DUTY_W+PWM_W-1:DUTY_W];
            lo_reg <= lo_prod[DUTY_W+PWM_W-1:DUTY_W];
        end
        if (cmd.load_out) begin
            m_tdata_reg <= {(M_TDATA_W-M_FIELDS_W)'(0), act_reg, lo_reg, hi_reg, duty_reg};
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

// File: sv/icmppt_ctrl.sv
// Controller state machine: sequences capture, the two divisions, the decision and the output beat.
// Depends on icmppt_pkg for the state, command and status types.
module icmppt_ctrl import icmppt_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_CLASSIFY;
            ST_CLASSIFY: begin
                if (sts.dv_small || (sts.v_zero && !sts.i_zero)) begin
                    state_next = ST_STEP;
                end else if (sts.v_zero) begin
                    state_next = ST_DIV2;
                end else begin
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:     if (sts.div_done) state_next = ST_DIV2;
            ST_DIV2:     if (sts.div_done) state_next = ST_DECIDE;
            ST_DECIDE:   state_next = ST_STEP;
            ST_STEP:     state_next = ST_PWM;
            ST_PWM:      state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_CLASSIFY: begin
                if (sts.dv_small) begin
                    cmd.act_load = 1'b1;
                    cmd.act_src  = SRC_DI;
                end else if (sts.v_zero && !sts.i_zero) begin
                    cmd.act_load = 1'b1;
                    cmd.act_src  = SRC_DEC;
                end else if (sts.v_zero) begin
                    // Zero voltage with zero current: the I/V term is zero.
                    cmd.clear_q1  = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DIV_DIDV;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DIV_IV;
                end
            end
            ST_DIV1: begin
                cmd.div_src = DIV_IV;
                if (sts.div_done) begin
                    cmd.save_q1   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DIV_DIDV;
                end
            end
            ST_DIV2: begin
                cmd.div_src = DIV_DIDV;
                cmd.save_g  = sts.div_done;
            end
            ST_DECIDE: begin
                cmd.act_load = 1'b1;
                cmd.act_src  = SRC_G;
            end
            ST_STEP:  cmd.step     = 1'b1;
            ST_PWM:   cmd.pwm      = 1'b1;
            ST_DONE:  cmd.load_out = out_free;
            default: ;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> state_reg == ST_CLASSIFY)
        else $error("accepted beat did not start a decision");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_tvalid)
        else $error("loaded result not presented");

endmodule

// File: sv/incremental_conductance_mppt_unit.sv
// Incremental conductance MPPT unit: one duty decision and PWM compare pair per sample beat.
// Depends on icmppt_pkg; instantiates icmppt_ctrl and icmppt_dp (which holds icmppt_div).
//
// Each accepted s_ beat (panel voltage and current, Q8.8) yields exactly one m_ beat with the
// new clamped duty (Q0.16), the high and low PWM compare counts and the step decision. The
// block handles one sample at a time. A beat whose voltage change sits inside the dead band,
// or whose voltage is zero with current flowing, goes from classification straight to the
// duty step, PWM and output states. Otherwise the conductance sum needs two passes through the
// shared bit-serial divider (I/V, then dI/dV; 32 quotient bits each) before the decision,
// step, PWM and output states. Zero voltage with zero current skips the I/V pass. The next
// sample is taken once the result sits in the output register, while that result waits for
// the consumer; a consumer that still holds off the previous result stalls the block in its
// final state until the output register frees up.
// Configuration writes are taken at any time (cfg_ready is always high) but are meant to land
// only while no sample is in flight; an index past the last register is ignored.
module incremental_conductance_mppt_unit import icmppt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // pv_voltage, pv_current
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // duty_fraction, pwm_high_count,
                                             // pwm_low_count, step_action, zero fill
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    icmppt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    icmppt_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata)
    );

endmodule
